// ----- rtl/core/gha_pkg.sv -----
// Shared types and constants for the generational handle allocator.
// No dependencies; imported by the controller, datapath and top level.
package gha_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int GEN_BITS_DEF   = 16;
  localparam int TAG_W          = 64;
  localparam int ACT_W          = 2;

  localparam logic [ACT_W-1:0] ACT_CREATE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DESTROY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic fs_rd;
    logic slot_rd_in;
    logic slot_rd_fs;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic create_pop;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/core/gha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the slot table and the free stack.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/gha_ctrl.sv -----
// Request sequencer for the handle allocator: accepts a beat, orders the
// memory reads and the commit. Depends on gha_pkg.
module gha_ctrl import gha_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.create_pop ? ST_POP : ST_DONE;
        end
      end
      ST_POP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.latch      = in_valid;
        cmd.fs_rd      = in_valid && stat.create_pop;
        cmd.slot_rd_in = in_valid && !stat.create_pop;
      end
      ST_POP: begin
        // popped index is on the stack read port: fetch its slot
        cmd.slot_rd_fs = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    // take no beat while reset is held
    if (!rst_n) begin
      in_stall = 1'b1;
      cmd      = '0;
    end
  end

endmodule

// ----- rtl/core/gha_dp.sv -----
// Datapath of the handle allocator: request latch, slot table, free stack,
// fill and stack counters and the result register. Depends on gha_pkg, gha_ram.
module gha_dp import gha_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF,
  localparam int IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [IDX_W-1:0]    in_handle_index,
  input  logic [GEN_BITS-1:0] in_handle_generation,
  input  logic [TAG_W-1:0]    in_new_tag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic                out_full_res,
  output logic [IDX_W-1:0]    out_index,
  output logic [GEN_BITS-1:0] out_generation,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_W = 1 + GEN_BITS + TAG_W;

  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    fc_r, fc_nxt;
  logic [ACT_W-1:0]    req_action_r;
  logic [IDX_W-1:0]    req_idx_r;
  logic [GEN_BITS-1:0] req_gen_r;
  logic [TAG_W-1:0]    req_tag_r;

  logic                out_valid_r;
  logic                res_ok_r, res_ok_nxt;
  logic                res_full_r, res_full_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [GEN_BITS-1:0] res_gen_r, res_gen_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;

  logic [CNT_W-1:0]    fc_dec;
  logic [IDX_W-1:0]    fs_rdata;
  logic                fs_we;
  logic [SLOT_W-1:0]   slot_rdata;
  logic                slot_we;
  logic [IDX_W-1:0]    slot_waddr;
  logic [SLOT_W-1:0]   slot_wdata;
  logic [IDX_W-1:0]    slot_raddr;

  logic                slot_alive;
  logic [GEN_BITS-1:0] slot_gen;
  logic [TAG_W-1:0]    slot_tag;
  logic                live;

  assign fc_dec     = fc_r - CNT_W'(1);
  assign slot_raddr = cmd.slot_rd_fs ? fs_rdata : in_handle_index;

  assign slot_alive = slot_rdata[SLOT_W-1];
  assign slot_gen   = slot_rdata[TAG_W +: GEN_BITS];
  assign slot_tag   = slot_rdata[TAG_W-1:0];

  // never-used slots sit at or above the fill count and count as dead
  assign live = (CNT_W'(req_idx_r) < used_r) && slot_alive && (slot_gen == req_gen_r);

  assign stat.create_pop = (in_action == ACT_CREATE) && (fc_r != '0);
  assign stat.out_busy   = out_valid_r && out_stall;

  gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fc_r[IDX_W-1:0]),
    .wdata (req_idx_r),
    .re    (cmd.fs_rd),
    .raddr (fc_dec[IDX_W-1:0]),
    .rdata (fs_rdata)
  );

  gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_table (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.slot_rd_in || cmd.slot_rd_fs),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_comb begin
    used_nxt     = used_r;
    fc_nxt       = fc_r;
    fs_we        = 1'b0;
    slot_we      = 1'b0;
    slot_waddr   = req_idx_r;
    slot_wdata   = {1'b0, slot_gen + GEN_BITS'(1), {TAG_W{1'b0}}};
    res_ok_nxt   = 1'b0;
    res_full_nxt = 1'b0;
    res_idx_nxt  = req_idx_r;
    res_gen_nxt  = req_gen_r;
    res_tag_nxt  = '0;
    case (req_action_r)
      ACT_CREATE: begin
        if (fc_r != '0) begin
          // reuse the most recently freed slot, keep its generation
          slot_waddr  = fs_rdata;
          slot_wdata  = {1'b1, slot_gen, req_tag_r};
          slot_we     = cmd.commit;
          fc_nxt      = fc_dec;
          res_ok_nxt  = 1'b1;
          res_idx_nxt = fs_rdata;
          res_gen_nxt = slot_gen;
        end else if (used_r < CNT_W'(SLOT_COUNT)) begin
          slot_waddr  = used_r[IDX_W-1:0];
          slot_wdata  = {1'b1, GEN_BITS'(1), req_tag_r};
          slot_we     = cmd.commit;
          used_nxt    = used_r + CNT_W'(1);
          res_ok_nxt  = 1'b1;
          res_idx_nxt = used_r[IDX_W-1:0];
          res_gen_nxt = GEN_BITS'(1);
        end else begin
          res_full_nxt = 1'b1;
        end
      end
      ACT_DESTROY: begin
        if (live && (fc_r < CNT_W'(SLOT_COUNT))) begin
          slot_we    = cmd.commit;
          fs_we      = cmd.commit;
          fc_nxt     = fc_r + CNT_W'(1);
          res_ok_nxt = 1'b1;
        end
      end
      ACT_QUERY: begin
        if (live) begin
          res_ok_nxt  = 1'b1;
          res_tag_nxt = slot_tag;
        end
      end
      default: begin
        res_ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        used_r      <= used_nxt;
        fc_r        <= fc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_action_r <= in_action;
      req_idx_r    <= in_handle_index;
      req_gen_r    <= in_handle_generation;
      req_tag_r    <= in_new_tag;
    end
    if (cmd.commit) begin
      res_ok_r   <= res_ok_nxt;
      res_full_r <= res_full_nxt;
      res_idx_r  <= res_idx_nxt;
      res_gen_r  <= res_gen_nxt;
      res_tag_r  <= res_tag_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = res_ok_r;
  assign out_full_res   = res_full_r;
  assign out_index      = res_idx_r;
  assign out_generation = res_gen_r;
  assign out_tag        = res_tag_r;

endmodule

// ----- rtl/core/generational_handle_allocator_core.sv -----
// Generational handle allocator: slot table that hands out index/generation
// handles for create, destroy and query requests.
// Channels: the request channel (in_valid/in_stall) carries one beat per
//   request: in_action (create, destroy, query), the handle and the tag to
//   store. The result channel (out_valid/out_stall) returns exactly one beat
//   per request: ok, full_res, the handle and the tag of a live query.
// Order: the result is offered from the output register after the commit
//   step; a create that reuses a freed slot first reads the free stack, then
//   the slot. The slot table is read once and written at most once per
//   request, and the sequencer takes a new beat only when back in idle, so a
//   request is not taken before the previous one has been committed.
// A new request may be taken while the previous result still waits in the
//   output register; if the receiver stalls, the next result holds in the
//   commit step and no further request is taken until it can be placed.
// Reset empties the table: the fill count and free-stack depth go to zero,
//   no slot is live, and no clearing pass is needed. in_stall stays high
//   while rst_n is low.
// Depends on gha_pkg, gha_ctrl, gha_dp and gha_ram.
module generational_handle_allocator_core import gha_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF,
  localparam int IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [IDX_W-1:0]    in_handle_index,
  input  logic [GEN_BITS-1:0] in_handle_generation,
  input  logic [TAG_W-1:0]    in_new_tag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic                out_full_res,
  output logic [IDX_W-1:0]    out_index,
  output logic [GEN_BITS-1:0] out_generation,
  output logic [TAG_W-1:0]    out_tag
);

  cmd_t  cmd;
  stat_t stat;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gha_dp #(.SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_action            (in_action),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .in_new_tag           (in_new_tag),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_ok               (out_ok),
    .out_full_res         (out_full_res),
    .out_index            (out_index),
    .out_generation       (out_generation),
    .out_tag              (out_tag)
  );

endmodule
